FILE: src/sra_pkg.sv
package sra_pkg;

	// request field widths
	localparam int REQ_DIM_W = 9;

	// result field widths
	localparam int POS_W      = 8;
	localparam int PAGE_NUM_W = 7;
	localparam int STATUS_W   = 2;

	// default page geometry and page count
	localparam int DEF_PAGE_WIDTH  = 256;
	localparam int DEF_PAGE_HEIGHT = 256;
	localparam int DEF_MAX_PAGES   = 128;

	// request types
	localparam logic REQ_ALLOC   = 1'b0;
	localparam logic REQ_RESTART = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK              = 2'd0;
	localparam logic [STATUS_W-1:0] ST_TOO_LARGE       = 2'd1;
	localparam logic [STATUS_W-1:0] ST_PAGES_EXHAUSTED = 2'd2;

	typedef struct packed {
		logic                 req_type;
		logic [REQ_DIM_W-1:0] req_width;
		logic [REQ_DIM_W-1:0] req_height;
	} req_t;

	typedef struct packed {
		logic [POS_W-1:0]      pos_x;
		logic [POS_W-1:0]      pos_y;
		logic [PAGE_NUM_W-1:0] page_num;
		logic [STATUS_W-1:0]   status;
	} rsp_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_START,
		S_SCAN,
		S_DECIDE,
		S_FILL,
		S_RESP
	} state_t;

endpackage

FILE: src/skyline_rect_allocator.sv
// Skyline rectangle allocator: packs w x h rectangles into pages of PAGE_WIDTH x PAGE_HEIGHT
// texels, keeping one height per column in a profile memory, and returns one result beat per
// request beat. An allocate takes the leftmost start column whose window maximum is lowest; a
// failed allocate moves to a fresh page, if one is left, and tries once more. Timing is set by the
// profile memory, which gives one column a cycle. The scan skips past any column that blocks a
// window and stops once a window of empty columns is found or the next start column plus w
// reaches PAGE_WIDTH. The scan re-reads part of each accepted window, since it restarts just
// past that window's highest column. Placing then writes w columns, one a cycle, and a non-empty
// allocate also passes through a start, a decide and a response state. A restart, a page change
// and the end of reset each clear every column of the profile; after reset no request is taken
// until that first clearing pass is over. Only one request is in work at a time, but a new
// request is taken while the last result beat is still stalled at the output.
module skyline_rect_allocator #(
	parameter int PAGE_WIDTH  = sra_pkg::DEF_PAGE_WIDTH,
	parameter int PAGE_HEIGHT = sra_pkg::DEF_PAGE_HEIGHT,
	parameter int MAX_PAGES   = sra_pkg::DEF_MAX_PAGES
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  sra_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output sra_pkg::rsp_t rsp
);
	import sra_pkg::*;

	localparam int AW  = (PAGE_WIDTH > 1) ? $clog2(PAGE_WIDTH) : 1;
	localparam int IW  = $clog2(PAGE_WIDTH + 1);
	localparam int SW  = ((IW > REQ_DIM_W) ? IW : REQ_DIM_W) + 1;
	localparam int HW  = $clog2(PAGE_HEIGHT + 1);
	localparam int HSW = ((HW > REQ_DIM_W) ? HW : REQ_DIM_W) + 1;
	localparam int PW  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;

	// column height profile
	logic [HW-1:0] col_mem [PAGE_WIDTH];
	logic [HW-1:0] rdata_q;
	logic [AW-1:0] rd_addr;
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [HW-1:0] mem_wd;

	state_t state_q, state_d, after_clr_q;

	logic [IW-1:0]        i_q;
	logic [AW-1:0]        k_q;
	logic [AW-1:0]        p_q;
	logic [HW-1:0]        top_q;
	logic [HW-1:0]        best_q;
	logic [AW-1:0]        bx_q;
	logic                 found_q;
	logic [REQ_DIM_W-1:0] w_q;
	logic [REQ_DIM_W-1:0] h_q;
	logic [PW-1:0]        page_q;
	logic                 retry_q;
	logic [IW-1:0]        cnt_q;
	rsp_t                 res_q;
	rsp_t                 rsp_q;
	logic                 rsp_valid_q;

	logic          req_acc;
	logic          rsp_free;
	logic          blocked;
	logic          win_last;
	logic          jump;
	logic          scan_end;
	logic [HW-1:0] top_nx;
	logic [AW-1:0] p_nx;
	logic [SW-1:0] restart_i;
	logic [AW-1:0] next_k;
	logic          too_wide;
	logic          fits;
	logic          last_page;
	logic          clr_done;
	logic          fill_done;

	assign req_stall = (state_q != S_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	// window check on the column that has just been read
	always_comb begin
		blocked   = (rdata_q >= best_q);
		top_nx    = (rdata_q > top_q) ? rdata_q : top_q;
		p_nx      = (rdata_q >= top_q) ? k_q : p_q;
		win_last  = (SW'(k_q) == SW'(i_q) + SW'(w_q) - SW'(1));
		jump      = blocked || win_last;
		restart_i = blocked ? (SW'(k_q) + SW'(1)) : (SW'(p_nx) + SW'(1));
		scan_end  = jump && ((!blocked && (top_nx == '0)) ||
			(restart_i + SW'(w_q) >= SW'(PAGE_WIDTH)));
		next_k    = jump ? AW'(restart_i) : (k_q + AW'(1));
	end

	// decision terms
	always_comb begin
		too_wide  = (SW'(w_q) >= SW'(PAGE_WIDTH));
		fits      = found_q && (HSW'(best_q) + HSW'(h_q) <= HSW'(PAGE_HEIGHT));
		last_page = ((PW + 1)'(page_q) + (PW + 1)'(1) >= (PW + 1)'(MAX_PAGES));
		clr_done  = (cnt_q == IW'(PAGE_WIDTH - 1));
		fill_done = (SW'(cnt_q) == SW'(w_q) - SW'(1));
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_done) begin
					state_d = after_clr_q;
				end
			end
			S_IDLE: begin
				if (req_acc) begin
					if (req.req_type == REQ_RESTART) begin
						state_d = S_CLEAR;
					end else if (req.req_width == '0 || req.req_height == '0) begin
						state_d = S_RESP;
					end else begin
						state_d = S_START;
					end
				end
			end
			S_START: begin
				state_d = too_wide ? S_DECIDE : S_SCAN;
			end
			S_SCAN: begin
				if (scan_end) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (fits) begin
					state_d = S_FILL;
				end else if (retry_q || last_page) begin
					state_d = S_RESP;
				end else begin
					state_d = S_CLEAR;
				end
			end
			S_FILL: begin
				if (fill_done) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (rsp_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// memory port controls
	always_comb begin
		rd_addr = k_q;
		mem_we  = 1'b0;
		mem_wa  = AW'(cnt_q);
		mem_wd  = '0;
		case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
			end
			S_START: begin
				rd_addr = '0;
			end
			S_SCAN: begin
				rd_addr = next_k;
			end
			S_FILL: begin
				mem_we = 1'b1;
				mem_wa = bx_q + AW'(cnt_q);
				mem_wd = HW'(HSW'(best_q) + HSW'(h_q));
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// profile memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			col_mem[mem_wa] <= mem_wd;
		end
		rdata_q <= col_mem[rd_addr];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			after_clr_q <= S_IDLE;
			cnt_q       <= '0;
			page_q      <= '0;
			retry_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_CLEAR: begin
					cnt_q <= clr_done ? '0 : cnt_q + IW'(1);
				end
				S_IDLE: begin
					cnt_q   <= '0;
					retry_q <= 1'b0;
					if (req_acc && req.req_type == REQ_RESTART) begin
						page_q      <= '0;
						after_clr_q <= S_RESP;
					end
				end
				S_DECIDE: begin
					cnt_q <= '0;
					if (!fits && !retry_q && !last_page) begin
						page_q      <= page_q + PW'(1);
						retry_q     <= 1'b1;
						after_clr_q <= S_START;
					end
				end
				S_FILL: begin
					cnt_q <= cnt_q + IW'(1);
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
			// output beat register
			if (state_q == S_RESP && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// scan and result datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				w_q   <= req.req_width;
				h_q   <= req.req_height;
				res_q <= '{pos_x: '0, pos_y: '0, page_num: '0,
					status: (req.req_type == REQ_ALLOC) ? ST_TOO_LARGE : ST_OK};
			end
			S_START: begin
				i_q     <= '0;
				k_q     <= '0;
				p_q     <= '0;
				top_q   <= '0;
				best_q  <= HW'(PAGE_HEIGHT);
				found_q <= 1'b0;
			end
			S_SCAN: begin
				if (!blocked && win_last) begin
					bx_q    <= AW'(i_q);
					best_q  <= top_nx;
					found_q <= 1'b1;
				end
				if (jump) begin
					i_q   <= IW'(restart_i);
					top_q <= '0;
				end else begin
					top_q <= top_nx;
					p_q   <= p_nx;
				end
				k_q <= next_k;
			end
			S_DECIDE: begin
				if (fits) begin
					res_q <= '{pos_x: POS_W'(bx_q), pos_y: POS_W'(best_q),
						page_num: PAGE_NUM_W'(page_q), status: ST_OK};
				end else if (retry_q) begin
					res_q <= '{pos_x: '0, pos_y: '0, page_num: '0, status: ST_TOO_LARGE};
				end else begin
					res_q <= '{pos_x: '0, pos_y: '0, page_num: '0,
						status: ST_PAGES_EXHAUSTED};
				end
			end
			S_RESP: begin
				if (rsp_free) begin
					rsp_q <= res_q;
				end
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

endmodule
